/* design/ble_ad_structure_parser_macros.svh */
// ----------------------------------------------------------------------------
// ble_ad_structure_parser_macros
// assertion macros shared by the advertising data parser
// ----------------------------------------------------------------------------
`ifndef BLE_AD_STRUCTURE_PARSER_MACROS_SVH
`define BLE_AD_STRUCTURE_PARSER_MACROS_SVH

// condition implies consequence in the same cycle
`define BLEADP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define BLEADP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/bleadp_pkg.sv */
// ----------------------------------------------------------------------------
// bleadp_pkg
// types and constants of the advertising data structure parser
// ----------------------------------------------------------------------------
package bleadp_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_PUSH    = 3;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA
    } t_phase;

    typedef enum logic [3:0] {
        KIND_FLAGS       = 4'd0,
        KIND_TX_POWER    = 4'd1,
        KIND_DEV_CLASS   = 4'd2,
        KIND_DEVICE_ID   = 4'd3,
        KIND_APPEARANCE  = 4'd4,
        KIND_COMPANY     = 4'd5,
        KIND_UUID16      = 4'd6,
        KIND_UUID32      = 4'd7,
        KIND_UUID128_LO  = 4'd8,
        KIND_UUID128_HI  = 4'd9,
        KIND_OTHER       = 4'd10,
        KIND_END         = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_TERMINATED = 2'd1,
        ST_TRUNCATED  = 2'd2
    } t_status;

    localparam logic [7:0] AD_FLAGS          = 8'h01;
    localparam logic [7:0] AD_UUID16_PART    = 8'h02;
    localparam logic [7:0] AD_UUID16_FULL    = 8'h03;
    localparam logic [7:0] AD_UUID32_PART    = 8'h04;
    localparam logic [7:0] AD_UUID32_FULL    = 8'h05;
    localparam logic [7:0] AD_UUID128_PART   = 8'h06;
    localparam logic [7:0] AD_UUID128_FULL   = 8'h07;
    localparam logic [7:0] AD_TX_POWER       = 8'h0A;
    localparam logic [7:0] AD_DEV_CLASS      = 8'h0D;
    localparam logic [7:0] AD_DEVICE_ID      = 8'h10;
    localparam logic [7:0] AD_APPEARANCE     = 8'h19;
    localparam logic [7:0] AD_MANUFACTURER   = 8'hFF;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ad_type;
        logic [7:0]  net_length;
        logic [63:0] value;
        logic [6:0]  element_count;
        t_status     status;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [1:0]          count;
        t_result [2:0]       slots;
    } t_push;

    typedef struct packed {
        logic        present;
        t_kind       kind;
        logic [63:0] value;
    } t_elem_end;

endpackage

/* design/bleadp_front.sv */
// ----------------------------------------------------------------------------
// bleadp_front
// splits incoming words into elements and builds up to three results per word
// ----------------------------------------------------------------------------
module bleadp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output bleadp_pkg::t_push o_push
);
    import bleadp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_net_len, n_net_len;
    logic [7:0]  r_index, n_index;
    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_count, n_count;
    logic        r_term, n_term;

    logic [7:0]  type_nl;
    logic [7:0]  rem_dec;
    logic [4:0]  unit;
    logic [2:0]  hmask;
    logic [2:0]  q;
    logic [63:0] acc_uuid;
    logic        uuid_v;
    t_kind       uuid_kind;
    logic [63:0] uuid_val;
    logic        fin_req;
    logic        fin_v;
    t_elem_end   ek;
    t_result     res_uuid, res_fin, res_end;
    t_status     end_status;

    function automatic logic [4:0] uuid_unit(input logic [7:0] t);
        logic [4:0] u;
        u = 5'd0;
        if (t == AD_UUID16_PART || t == AD_UUID16_FULL) u = 5'd2;
        if (t == AD_UUID32_PART || t == AD_UUID32_FULL) u = 5'd4;
        if (t == AD_UUID128_PART || t == AD_UUID128_FULL) u = 5'd16;
        return u;
    endfunction

    function automatic t_elem_end end_kind(input logic [7:0] t, input logic [7:0] nl,
                                           input logic [63:0] acc, input logic [4:0] u);
        t_elem_end e;
        e.present = 1'b1;
        e.kind    = KIND_OTHER;
        e.value   = '0;
        if (u != 5'd0) begin
            e.present = (nl < {3'b000, u});
        end else begin
            case (t)
                AD_FLAGS: begin
                    if (nl >= 8'd1) begin
                        e.kind  = KIND_FLAGS;
                        e.value = {56'd0, acc[7:0]};
                    end
                end
                AD_TX_POWER: begin
                    if (nl >= 8'd1) begin
                        e.kind  = KIND_TX_POWER;
                        e.value = {{56{acc[7]}}, acc[7:0]};
                    end
                end
                AD_DEV_CLASS: begin
                    if (nl >= 8'd3) begin
                        e.kind  = KIND_DEV_CLASS;
                        e.value = {40'd0, acc[23:0]};
                    end
                end
                AD_DEVICE_ID: begin
                    if (nl >= 8'd8) begin
                        e.kind  = KIND_DEVICE_ID;
                        e.value = acc;
                    end
                end
                AD_APPEARANCE: begin
                    if (nl >= 8'd2) begin
                        e.kind  = KIND_APPEARANCE;
                        e.value = {48'd0, acc[15:0]};
                    end
                end
                AD_MANUFACTURER: begin
                    if (nl >= 8'd2) begin
                        e.kind  = KIND_COMPANY;
                        e.value = {48'd0, acc[15:0]};
                    end
                end
                default: begin
                    e.kind = KIND_OTHER;
                end
            endcase
        end
        return e;
    endfunction

    assign type_nl = r_remaining - 8'd1;
    assign rem_dec = r_remaining - 8'd1;
    assign unit    = uuid_unit(r_type);
    assign hmask   = (unit == 5'd2) ? 3'd1 : ((unit == 5'd4) ? 3'd3 : 3'd7);
    assign q       = r_index[2:0] & hmask;
    assign acc_uuid = ((q == 3'd0) ? 64'd0 : r_acc)
                    | ({56'd0, i_data_byte} << {q, 3'b000});

    // next state
    always_comb begin
        n_phase = r_phase;
        if (!r_term) begin
            case (r_phase)
                PH_LEN: begin
                    if (i_data_byte != 8'd0) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_phase = (type_nl == 8'd0) ? PH_LEN : PH_DATA;
                end
                PH_DATA: begin
                    if (rem_dec == 8'd0) n_phase = PH_LEN;
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

    // datapath and results
    always_comb begin
        n_remaining = r_remaining;
        n_type      = r_type;
        n_net_len   = r_net_len;
        n_index     = r_index;
        n_acc       = r_acc;
        n_count     = r_count;
        n_term      = r_term;
        uuid_v      = 1'b0;
        uuid_kind   = KIND_OTHER;
        uuid_val    = '0;
        fin_req     = 1'b0;
        if (!r_term) begin
            case (r_phase)
                PH_LEN: begin
                    if (i_data_byte == 8'd0) n_term = 1'b1;
                    else n_remaining = i_data_byte;
                end
                PH_TYPE: begin
                    n_type      = i_data_byte;
                    n_net_len   = type_nl;
                    n_remaining = type_nl;
                    n_index     = 8'd0;
                    n_acc       = '0;
                    fin_req     = (type_nl == 8'd0);
                end
                PH_DATA: begin
                    if (unit != 5'd0) begin
                        n_acc = acc_uuid;
                        if (q == hmask) begin
                            uuid_v = 1'b1;
                            case (hmask)
                                3'd1: begin
                                    uuid_kind = KIND_UUID16;
                                    uuid_val  = {48'd0, acc_uuid[15:0]};
                                end
                                3'd3: begin
                                    uuid_kind = KIND_UUID32;
                                    uuid_val  = {32'd0, acc_uuid[31:0]};
                                end
                                default: begin
                                    uuid_kind = r_index[3] ? KIND_UUID128_HI : KIND_UUID128_LO;
                                    uuid_val  = acc_uuid;
                                end
                            endcase
                        end
                    end else if (r_index < 8'd8) begin
                        n_acc = r_acc | ({56'd0, i_data_byte} << {r_index[2:0], 3'b000});
                    end
                    n_index     = r_index + 8'd1;
                    n_remaining = rem_dec;
                    fin_req     = (rem_dec == 8'd0);
                end
                default: begin
                    n_term = r_term;
                end
            endcase
        end
        if (fin_req && r_count != 7'h7F) n_count = r_count + 7'd1;
    end

    assign ek    = end_kind(n_type, n_net_len, n_acc, uuid_unit(n_type));
    assign fin_v = fin_req && ek.present;

    assign end_status = n_term ? ST_TERMINATED
                      : ((n_phase == PH_LEN) ? ST_COMPLETE : ST_TRUNCATED);

    always_comb begin
        res_uuid = '{kind: uuid_kind, ad_type: r_type, net_length: r_net_len,
                     value: uuid_val, element_count: r_count, status: ST_COMPLETE,
                     last_result: 1'b0};
        res_fin  = '{kind: ek.kind, ad_type: n_type, net_length: n_net_len,
                     value: ek.value, element_count: n_count, status: ST_COMPLETE,
                     last_result: 1'b0};
        res_end  = '{kind: KIND_END, ad_type: 8'd0, net_length: 8'd0,
                     value: 64'd0, element_count: n_count, status: end_status,
                     last_result: 1'b1};
        o_push.count    = {1'b0, uuid_v} + {1'b0, fin_v} + {1'b0, i_last_byte};
        o_push.slots[0] = uuid_v ? res_uuid : (fin_v ? res_fin : res_end);
        o_push.slots[1] = (uuid_v && fin_v) ? res_fin : res_end;
        o_push.slots[2] = res_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase     <= PH_LEN;
            r_remaining <= '0;
            r_type      <= '0;
            r_net_len   <= '0;
            r_index     <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_term      <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_type      <= n_type;
            r_net_len   <= n_net_len;
            r_index     <= n_index;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_term      <= n_term;
        end
    end

endmodule

/* design/bleadp_queue.sv */
// ----------------------------------------------------------------------------
// bleadp_queue
// result queue taking up to three words per cycle while ready and giving one per cycle while the reader is ready
// ----------------------------------------------------------------------------
module bleadp_queue #(
    parameter int P_DEPTH = bleadp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bleadp_pkg::t_push   i_item,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output bleadp_pkg::t_result o_head
);
    import bleadp_pkg::*;

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_result        r_mem [P_DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_level, n_level;
    logic [PW-1:0]  w1, w2, w3;
    logic [1:0]     push_n;
    logic           pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(P_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w1     = wrap_inc(r_wr);
    assign w2     = wrap_inc(w1);
    assign w3     = wrap_inc(w2);
    assign push_n = i_push ? i_item.count : 2'd0;
    assign pop    = o_valid && i_ready;

    assign o_valid = (r_level != '0);
    assign o_ready = (r_level <= CW'(P_DEPTH - MAX_PUSH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        case (push_n)
            2'd1:    n_wr = w1;
            2'd2:    n_wr = w2;
            2'd3:    n_wr = w3;
            default: n_wr = r_wr;
        endcase
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_level = r_level + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n > 2'd0) r_mem[r_wr] <= i_item.slots[0];
        if (push_n > 2'd1) r_mem[w1]   <= i_item.slots[1];
        if (push_n > 2'd2) r_mem[w2]   <= i_item.slots[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

endmodule

/* design/ble_ad_structure_parser.sv */
// ----------------------------------------------------------------------------
// ble_ad_structure_parser
// advertising / extended inquiry data parser, one byte per word
// ----------------------------------------------------------------------------
// One input byte is taken every clock while o_ready is high; the element
// state is updated in the same cycle it is accepted. A byte causes zero to
// three results, which are written to a queue of P_QUEUE_DEPTH entries and
// leave one per clock from its head while i_ready is high. The input stalls
// while fewer than three entries are free, so the sustained rate is one byte
// per cycle as long as results are taken at least as fast as they are made.
// ----------------------------------------------------------------------------
module ble_ad_structure_parser #(
    parameter int P_QUEUE_DEPTH = bleadp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_ad_type,
    output logic [7:0]  o_net_length,
    output logic [63:0] o_value,
    output logic [6:0]  o_element_count,
    output logic [1:0]  o_status,
    output logic        o_last_result
);
    import bleadp_pkg::*;

`include "ble_ad_structure_parser_macros.svh"

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = i_valid && o_ready;

    bleadp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    bleadp_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (push),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_ad_type       = head.ad_type;
    assign o_net_length    = head.net_length;
    assign o_value         = head.value;
    assign o_element_count = head.element_count;
    assign o_status        = head.status;
    assign o_last_result   = head.last_result;

    `BLEADP_ASSERT_IMPL(a_last_is_end, o_valid && o_last_result, o_kind == KIND_END,
        "last result word is not an end result")
    `BLEADP_ASSERT_IMPL(a_status_only_on_end, o_valid && o_kind != KIND_END,
        o_status == ST_COMPLETE && !o_last_result, "status set on element result")
    `BLEADP_ASSERT_IMPL(a_stall_has_data, !o_ready, o_valid,
        "input stalled while result queue is empty")
    `BLEADP_ASSERT_IMPL(a_uuid16_width, o_valid && o_kind == KIND_UUID16,
        o_value[63:16] == 48'd0, "uuid16 value wider than 16 bits")

endmodule
